// ===== rtl/core/tdsac_pkg.sv =====
`default_nettype none
package tdsac_pkg;

  localparam int MAX_BATCH  = 32;
  localparam int SAMPLE_MAX = 26400;
  localparam int D_MAX      = 2447;   // largest t16 + 400 for a 12-bit temperature
  localparam int FRAC       = 16;

  localparam int CNT_W = $clog2(MAX_BATCH + 1);
  localparam int SUM_W = $clog2(MAX_BATCH * SAMPLE_MAX + 1);
  localparam int DEN_W = $clog2(10 * MAX_BATCH * D_MAX + 1);
  localparam int NUM_W = SUM_W + FRAC;
  localparam int QC_W  = $clog2(NUM_W + 1);
  localparam int XW    = 20;          // compensated voltage, Q4.16
  localparam int SQ_W  = 2 * XW;
  localparam int P_W   = SQ_W + 14;
  localparam int Q_W   = 40;
  localparam int R_W   = Q_W + XW;
  localparam int SCL_SH = 31;
  localparam int RCP_SH = 32;         // ceil(2^32 / 25) is exact below 2^30

  localparam logic [13:0] K_SQ  = 14'd13342;
  localparam logic [14:0] K_LIN = 15'd25586;
  localparam logic [16:0] K_C   = 17'd85739;
  localparam logic [27:0] K_RCP = 28'd171798692;
  localparam logic [19:0] TDS_MAX = 20'hFFFFF;

  typedef struct packed {
    logic signed [15:0] sample_raw;
    logic               last_sample;
    logic signed [11:0] water_temp_sixteenths;
    logic               water_temp_valid;
  } in_t;

  typedef struct packed {
    logic [19:0] tds_ppm_sixteenths;
    logic        tds_valid;
    logic [14:0] mean_counts;
    logic [5:0]  valid_samples;
    logic        batch_overflow;
  } out_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_VC
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_W,
    ST_VC,
    ST_VC_W,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_SCL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     cap_den;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_mean;
    logic     cap_vc;
    logic     mul1;
    logic     mul2;
    logic     mul3;
    logic     mul4;
    logic     cap_t;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/tds_sample_average_convert.sv =====
`default_nettype none
// TDS batch averager: samples (125 uV counts) stream in, one per accepted item;
// counts in 0..26400 are summed, up to MAX_BATCH of them, extras set the
// overflow flag. A non-final item is taken without a stall. The item flagged
// last_sample closes the batch and yields one result after these steps: two
// passes of the shared one-bit-per-cycle divider (mean, compensated voltage),
// four multiply steps for the cubic, one reciprocal multiply for the final
// scale by 25 and an output load. in_stall stays high after the closing item
// until the output load, longer if the previous result is still waiting.
// The result sits in an output register, so batch samples are taken again
// while it waits. adc_ready lives in word 0 (paddr[2] low).
module tds_sample_average_convert
  import tdsac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cmd_t             cmd;
  status_t          status;
  logic             adc_ready_r;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic             out_free;

  // register file: only adc_ready, bit 0 of word 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, adc_ready_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_ready_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      adc_ready_r <= pwdata[0];
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = out_free;

  tdsac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_sample),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tdsac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  tdsac_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .adc_ready (adc_ready_r),
    .div_quo   (div_quo),
    .div_num   (div_num),
    .div_den   (div_den),
    .out_free  (out_free),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tdsac_div.sv =====
`default_nettype none
module tdsac_div
  import tdsac_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [QC_W-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W+1:0] trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[NUM_W-1]} - {2'b00, den_r};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DEN_W+1]) begin
        rem_nxt = trial[DEN_W:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == QC_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

// ===== rtl/core/tdsac_ctrl.sv =====
`default_nettype none
module tdsac_ctrl
  import tdsac_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_last,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   acc;

  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (acc && in_last) state_nxt = ST_MEAN;
      ST_MEAN:   state_nxt = ST_MEAN_W;
      ST_MEAN_W: if (status.div_done) state_nxt = ST_VC;
      ST_VC:     state_nxt = ST_VC_W;
      ST_VC_W:   if (status.div_done) state_nxt = ST_MUL1;
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_MUL3;
      ST_MUL3:   state_nxt = ST_MUL4;
      ST_MUL4:   state_nxt = ST_SCL;
      ST_SCL:    state_nxt = ST_DONE;
      ST_DONE:   if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_MEAN;
    case (state_r)
      ST_IDLE:   cmd.load = acc;
      ST_MEAN: begin
        cmd.cap_den   = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
      end
      ST_MEAN_W: cmd.cap_mean = status.div_done;
      ST_VC: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_VC;
      end
      ST_VC_W:   cmd.cap_vc = status.div_done;
      ST_MUL1:   cmd.mul1 = 1'b1;
      ST_MUL2:   cmd.mul2 = 1'b1;
      ST_MUL3:   cmd.mul3 = 1'b1;
      ST_MUL4:   cmd.mul4 = 1'b1;
      ST_SCL:    cmd.cap_t = 1'b1;
      ST_DONE:   cmd.out_load = status.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tdsac_dp.sv =====
`default_nettype none
module tdsac_dp
  import tdsac_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  input  wire in_t              in_data,
  input  wire logic             adc_ready,
  input  wire logic [NUM_W-1:0] div_quo,
  output logic [NUM_W-1:0]      div_num,
  output logic [DEN_W-1:0]      div_den,
  output logic                  out_free,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output out_t                  out_data
);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic signed [12:0] d_r;
  logic [DEN_W-1:0] den_r;
  logic [14:0]      mean_r;
  logic [XW-1:0]    x_r;
  logic             vsat_r;
  logic [SQ_W-1:0]  sq_r;
  logic [P_W-1:0]   p_r;
  logic [XW+14:0]   lin_r;
  logic [Q_W-1:0]   q_r;
  logic [R_W-1:0]   r_r;
  logic [19:0]      t_r;
  logic             tsat_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r;

  logic             in_range;
  logic signed [12:0] d_in;
  logic             d_pos;
  logic [11:0]      d_mul;
  logic [CNT_W+11:0] cd;
  logic             valid;
  logic [19:0]      tds;
  logic [5:0]       cnt_sat;
  logic [R_W-SCL_SH+27:0] scl_prod;

  // sign bit checked explicitly: negatives fall outside the window
  assign in_range = !in_data.sample_raw[15] &&
                    (in_data.sample_raw <= 16'sd26400);
  assign d_in = in_data.water_temp_valid ?
                (13'(in_data.water_temp_sixteenths) + 13'sd400) : 13'sd800;
  assign d_pos = !d_r[12] && (d_r != 13'sd0);
  assign d_mul = d_pos ? d_r[11:0] : 12'd1;
  assign cd    = {12'd0, cnt_r} * {{CNT_W{1'b0}}, d_mul};

  // final divide by 25 as a reciprocal multiply on r >> 31
  assign scl_prod = (R_W-SCL_SH+28)'(r_r[R_W-1:SCL_SH]) * (R_W-SCL_SH+28)'(K_RCP);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (cmd.load && in_range) begin
      if (cnt_r < CNT_W'(MAX_BATCH)) begin
        sum_nxt = sum_r + SUM_W'(in_data.sample_raw[14:0]);
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.out_load) begin
      sum_nxt = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_MEAN: begin
        div_num = NUM_W'(sum_r);
        div_den = DEN_W'(cnt_r);
      end
      DIV_VC: begin
        div_num = {sum_r, {FRAC{1'b0}}};
        div_den = den_r;
      end
      default: begin
        div_num = '0;
        div_den = DEN_W'(1);
      end
    endcase
  end

  assign valid   = adc_ready && (cnt_r != '0);
  assign cnt_sat = (cnt_r > CNT_W'(63)) ? 6'd63 : 6'(cnt_r);

  always_comb begin
    if (!valid)                           tds = '0;
    else if (d_r == 13'sd0)               tds = TDS_MAX;
    else if (d_r[12] || (sum_r == '0))    tds = '0;
    else if (vsat_r || tsat_r)            tds = TDS_MAX;
    else                                  tds = t_r;
  end

  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.load)    d_r    <= d_in;
    if (cmd.cap_den) den_r  <= DEN_W'({cd, 3'b000} + {1'b0, cd, 1'b0});
    if (cmd.cap_mean) mean_r <= (cnt_r == '0) ? 15'd0 : div_quo[14:0];
    if (cmd.cap_vc) begin
      x_r    <= div_quo[XW-1:0];
      vsat_r <= (div_quo[NUM_W-1:XW] != '0);
    end
    if (cmd.mul1) sq_r <= {{XW{1'b0}}, x_r} * {{XW{1'b0}}, x_r};
    if (cmd.mul2) begin
      p_r   <= P_W'(sq_r) * P_W'(K_SQ);
      lin_r <= (XW+15)'(x_r) * (XW+15)'(K_LIN);
    end
    if (cmd.mul3) q_r <= Q_W'(p_r[P_W-1:FRAC]) + Q_W'({K_C, {FRAC{1'b0}}}) - Q_W'(lin_r);
    if (cmd.mul4) r_r <= R_W'(q_r) * R_W'(x_r);
    if (cmd.cap_t) begin
      t_r    <= scl_prod[RCP_SH+19:RCP_SH];
      tsat_r <= (scl_prod[R_W-SCL_SH+27:RCP_SH+20] != '0);
    end
    if (cmd.out_load) begin
      out_r.tds_ppm_sixteenths <= tds;
      out_r.tds_valid          <= valid;
      out_r.mean_counts        <= mean_r;
      out_r.valid_samples      <= cnt_sat;
      out_r.batch_overflow     <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
